### rtl/core/cbfe_pkg.sv
package cbfe_pkg;

  localparam logic [7:0] SYNC_RESET  = 8'h55;
  localparam logic [7:0] BEGIN_RESET = 8'h3C;
  localparam int         QDEPTH      = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_DATA,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEADER,
    PH_BEGIN,
    PH_TYPE,
    PH_LENGTH,
    PH_DATA,
    PH_CHECK,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_START_BUSY = 2'd1,
    ERR_DATA_DROP  = 2'd2
  } err_t;

  typedef enum logic {
    REG_SYNC  = 1'b0,
    REG_BEGIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] block_type;
    logic [7:0] block_length;
    logic [7:0] leader_length;
    logic [7:0] data_byte;
  } cmd_t;

  // queue to executor
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

### rtl/core/cassette_block_fsk_encoder.sv
// Cassette block encoder with FSK line output.
// Slave stream: s_tuser carries the opcode (tick, start block, data byte);
// s_tdata carries block_type, block_length, leader_length and data_byte.
// Master stream: one result beat per input beat with line level, busy flag,
// need-byte flag and error code, in the same order as the input beats.
// Configuration: cfg_we with cfg_index 0 writes the sync byte, 1 the begin
// byte; write only while no beat is in flight.
// Each input beat is stored in the command queue, and its command is applied
// from the queue head, with its result beat held in the result register.
// Throughput: one beat per cycle while m_tready takes results; each command
// updates the sequencer registers as it leaves a two-entry command queue.
// When m_tready is low the result register holds its beat, the queue fills,
// and s_tready drops once both queue entries are taken.
// Reset (rst, synchronous) empties the queue and result register, returns
// the sequencer to idle with the line high, and restores the sync byte 0x55
// and begin byte 0x3C.
module cassette_block_fsk_encoder import cbfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_type, block_length, leader_length, data_byte
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // line_level, busy_res, need_byte, error[1:0], zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  q_head_t head;
  logic    pop;

  cbfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  cbfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### rtl/core/cbfe_front.sv
module cbfe_front import cbfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_type, block_length, leader_length, data_byte
  input  logic [1:0]  s_tuser,   // opcode
  output q_head_t     head,
  input  logic        pop
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t           entry [QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push;
  logic           do_pop;
  cmd_t           cmd_in;

  always_comb begin
    cmd_in.block_type    = s_tdata[7:0];
    cmd_in.block_length  = s_tdata[15:8];
    cmd_in.leader_length = s_tdata[23:16];
    cmd_in.data_byte     = s_tdata[31:24];
    case (opcode_t'(s_tuser))
      OP_TICK:  cmd_in.kind = CMD_TICK;
      OP_START: cmd_in.kind = CMD_START;
      OP_DATA:  cmd_in.kind = CMD_DATA;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  assign s_tready   = (count != (PW+1)'(QDEPTH));
  assign push       = s_tvalid && s_tready;
  assign head.valid = (count != '0);
  assign head.cmd   = entry[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !push && !do_pop |=> $stable(count))
    else $error("queue count moved without push or pop");

endmodule

### rtl/core/cbfe_back.sv
module cbfe_back import cbfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  q_head_t    head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // line_level, busy_res, need_byte, error[1:0], zero pad
);

  logic [7:0] sync_byte;
  logic [7:0] begin_byte;

  logic       level_reg,    level_reg_next;
  phase_t     phase,        phase_next;
  logic [1:0] tick_in_bit,  tick_in_bit_next;
  logic [2:0] bit_index,    bit_index_next;
  logic [7:0] shift_byte,   shift_byte_next;
  logic [7:0] leader_left,  leader_left_next;
  logic [7:0] data_left,    data_left_next;
  logic [7:0] saved_length, saved_length_next;
  logic [7:0] running_sum,  running_sum_next;
  logic [7:0] held_byte,    held_byte_next;
  logic       held_valid,   held_valid_next;

  err_t       err;
  logic       start_ok;
  logic       byte_done;
  logic       stall;
  logic       done;
  logic [7:0] sb;
  logic [7:0] result;
  cmd_t       cmd;

  assign cmd = head.cmd;
  assign pop = head.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_RESET;
      begin_byte <= BEGIN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SYNC:  sync_byte  <= cfg_data;
        REG_BEGIN: begin_byte <= cfg_data;
        default:   ;
      endcase
    end
  end

  // datapath: byte load, bit timing, counters
  always_comb begin
    level_reg_next    = level_reg;
    tick_in_bit_next  = tick_in_bit;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    leader_left_next  = leader_left;
    data_left_next    = data_left;
    saved_length_next = saved_length;
    running_sum_next  = running_sum;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    err               = ERR_NONE;
    start_ok          = 1'b0;
    byte_done         = 1'b0;
    stall             = 1'b0;
    done              = 1'b0;
    sb                = shift_byte;
    case (cmd.kind)
      CMD_TICK: begin
        if (phase != PH_IDLE) begin
          if (tick_in_bit == 2'd0 && bit_index == 3'd0) begin
            case (phase)
              PH_LEADER: sb = sync_byte;
              PH_BEGIN:  sb = begin_byte;
              PH_TYPE:   sb = running_sum - saved_length;
              PH_LENGTH: sb = saved_length;
              PH_DATA: begin
                if (!held_valid) begin
                  stall = 1'b1;
                end else begin
                  sb               = held_byte;
                  held_valid_next  = 1'b0;
                  running_sum_next = running_sum + held_byte;
                  data_left_next   = data_left - 8'd1;
                end
              end
              PH_CHECK:  sb = running_sum;
              default:   sb = sync_byte;
            endcase
          end
          if (!stall) begin
            // toggle at bit start; ones toggle again on tick 1, zeros on tick 2
            if (tick_in_bit == 2'd0) begin
              level_reg_next = ~level_reg;
            end else if (sb[0]) begin
              level_reg_next = ~level_reg;
              done           = 1'b1;
            end else if (tick_in_bit == 2'd2) begin
              level_reg_next = ~level_reg;
            end else if (tick_in_bit == 2'd3) begin
              done = 1'b1;
            end
            if (done) begin
              tick_in_bit_next = 2'd0;
              shift_byte_next  = sb >> 1;
              if (bit_index == 3'd7) begin
                bit_index_next = 3'd0;
                byte_done      = 1'b1;
                if (phase == PH_LEADER) begin
                  leader_left_next = leader_left - 8'd1;
                end
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end else begin
              tick_in_bit_next = tick_in_bit + 2'd1;
              shift_byte_next  = sb;
            end
          end
        end
      end
      CMD_START: begin
        if (phase != PH_IDLE) begin
          err = ERR_START_BUSY;
        end else begin
          start_ok          = 1'b1;
          saved_length_next = cmd.block_length;
          leader_left_next  = cmd.leader_length;
          data_left_next    = cmd.block_length;
          running_sum_next  = cmd.block_type + cmd.block_length;
          tick_in_bit_next  = 2'd0;
          bit_index_next    = 3'd0;
          held_valid_next   = 1'b0;
        end
      end
      CMD_DATA: begin
        if (phase == PH_IDLE || data_left == 8'd0 || held_valid) begin
          err = ERR_DATA_DROP;
        end else begin
          held_byte_next  = cmd.data_byte;
          held_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (start_ok) begin
      phase_next = (cmd.leader_length != 8'd0) ? PH_LEADER : PH_BEGIN;
    end else if (byte_done) begin
      case (phase)
        PH_LEADER: if (leader_left_next == 8'd0) phase_next = PH_BEGIN;
        PH_BEGIN:  phase_next = PH_TYPE;
        PH_TYPE:   phase_next = PH_LENGTH;
        PH_LENGTH: phase_next = (saved_length != 8'd0) ? PH_DATA : PH_CHECK;
        PH_DATA:   if (data_left_next == 8'd0) phase_next = PH_CHECK;
        PH_CHECK:  phase_next = PH_TRAILER;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // result beat from the state after this command
  always_comb begin
    result      = '0;
    result[0]   = level_reg_next;
    result[1]   = (phase_next != PH_IDLE);
    result[2]   = (phase_next != PH_IDLE) && (data_left_next != 8'd0) && !held_valid_next;
    result[4:3] = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg    <= 1'b1;
      phase        <= PH_IDLE;
      tick_in_bit  <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      leader_left  <= '0;
      data_left    <= '0;
      saved_length <= '0;
      running_sum  <= '0;
      held_valid   <= 1'b0;
    end else if (pop) begin
      level_reg    <= level_reg_next;
      phase        <= phase_next;
      tick_in_bit  <= tick_in_bit_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      leader_left  <= leader_left_next;
      data_left    <= data_left_next;
      saved_length <= saved_length_next;
      running_sum  <= running_sum_next;
      held_valid   <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_byte <= held_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= result;
    end
  end

  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_in_bit == 2'd0 && bit_index == 3'd0)
    else $error("idle with a bit in flight");

  a_held_needs_room: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> data_left != 8'd0)
    else $error("held byte with no data byte due");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(phase) && $stable(level_reg))
    else $error("encoder state moved without a command");

endmodule

### verif/tb_cassette_block_fsk_encoder.sv
`timescale 1ns / 1ps

module tb_cassette_block_fsk_encoder;
  import cbfe_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic level;
    logic busy;
    logic need;
    err_t err;
  } line_status_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // block_type, block_length, leader_length, data_byte
  logic [1:0]  s_tuser;   // opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // line_level, busy_res, need_byte, error[1:0], zero pad
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  cassette_block_fsk_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // encoder state as the testbench sees it
  logic       mdl_level;
  phase_t     mdl_phase;
  logic [1:0] mdl_tick;
  logic [2:0] mdl_bit;
  logic [7:0] mdl_shift;
  logic [7:0] mdl_leader;
  logic [7:0] mdl_data_left;
  logic [7:0] mdl_len;
  logic [7:0] mdl_sum;
  logic [7:0] mdl_held;
  logic       mdl_held_full;
  logic [7:0] mdl_sync;
  logic [7:0] mdl_begin;

  line_status_t status_q[$];
  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;
  bit           hold_output;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic mdl_need();
    return mdl_phase != PH_IDLE && mdl_data_left != 8'd0 && !mdl_held_full;
  endfunction

  // returns 0 when a data byte is due but the holding register is empty
  function automatic logic fetch_byte();
    case (mdl_phase)
      PH_LEADER: mdl_shift = mdl_sync;
      PH_BEGIN:  mdl_shift = mdl_begin;
      PH_TYPE:   mdl_shift = mdl_sum - mdl_len;
      PH_LENGTH: mdl_shift = mdl_len;
      PH_DATA: begin
        if (!mdl_held_full) return 1'b0;
        mdl_shift = mdl_held;
        mdl_held_full = 1'b0;
        mdl_sum = mdl_sum + mdl_held;
        mdl_data_left = mdl_data_left - 8'd1;
      end
      PH_CHECK:  mdl_shift = mdl_sum;
      default:   mdl_shift = mdl_sync;
    endcase
    return 1'b1;
  endfunction

  function automatic void advance_phase();
    case (mdl_phase)
      PH_LEADER: begin
        mdl_leader = mdl_leader - 8'd1;
        if (mdl_leader == 8'd0) mdl_phase = PH_BEGIN;
      end
      PH_BEGIN:  mdl_phase = PH_TYPE;
      PH_TYPE:   mdl_phase = PH_LENGTH;
      PH_LENGTH: mdl_phase = (mdl_len != 8'd0) ? PH_DATA : PH_CHECK;
      PH_DATA: begin
        if (mdl_data_left == 8'd0) mdl_phase = PH_CHECK;
      end
      PH_CHECK:  mdl_phase = PH_TRAILER;
      default:   mdl_phase = PH_IDLE;
    endcase
  endfunction

  // one timer tick: a one is 2 ticks, a zero 4 ticks with a mid toggle
  function automatic void fsk_tick();
    logic one;
    logic done;
    if (mdl_phase == PH_IDLE) return;
    if (mdl_tick == 2'd0 && mdl_bit == 3'd0) begin
      if (!fetch_byte()) return;
    end
    one = mdl_shift[0];
    done = 1'b0;
    if (mdl_tick == 2'd0) begin
      mdl_level = ~mdl_level;
    end else if (one) begin
      mdl_level = ~mdl_level;
      done = 1'b1;
    end else if (mdl_tick == 2'd2) begin
      mdl_level = ~mdl_level;
    end else if (mdl_tick == 2'd3) begin
      done = 1'b1;
    end
    if (!done) begin
      mdl_tick = mdl_tick + 2'd1;
      return;
    end
    mdl_tick = 2'd0;
    mdl_shift = mdl_shift >> 1;
    if (mdl_bit == 3'd7) begin
      mdl_bit = 3'd0;
      advance_phase();
    end else begin
      mdl_bit = mdl_bit + 3'd1;
    end
  endfunction

  function automatic line_status_t encode_item(logic [1:0] op, logic [31:0] d);
    line_status_t res;
    res.err = ERR_NONE;
    case (op)
      OP_TICK: fsk_tick();
      OP_START: begin
        if (mdl_phase != PH_IDLE) begin
          res.err = ERR_START_BUSY;
        end else begin
          mdl_len = d[15:8];
          mdl_leader = d[23:16];
          mdl_data_left = d[15:8];
          mdl_sum = d[7:0] + d[15:8];
          mdl_tick = 2'd0;
          mdl_bit = 3'd0;
          mdl_held_full = 1'b0;
          mdl_phase = (mdl_leader != 8'd0) ? PH_LEADER : PH_BEGIN;
        end
      end
      OP_DATA: begin
        if (mdl_phase == PH_IDLE || mdl_data_left == 8'd0 || mdl_held_full) begin
          res.err = ERR_DATA_DROP;
        end else begin
          mdl_held = d[31:24];
          mdl_held_full = 1'b1;
        end
      end
      default: ;
    endcase
    res.level = mdl_level;
    res.busy = mdl_phase != PH_IDLE;
    res.need = mdl_need();
    return res;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    line_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (status_q.size() == 0) begin
        $display("%0t: result beat %h with nothing expected, actual %h", $time, m_tdata,
                 m_tdata);
        fail_count++;
      end else begin
        want = status_q.pop_front();
        check_field("line_level", want.level, m_tdata[0]);
        check_field("busy_res", want.busy, m_tdata[1]);
        check_field("need_byte", want.need, m_tdata[2]);
        check_field("error", want.err, m_tdata[4:3]);
        check_field("pad", 0, m_tdata[7:5]);
      end
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // returns at the edge where the beat is taken
  task automatic send_item(logic [1:0] op, logic [31:0] d);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    status_q.push_back(encode_item(op, d));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, $urandom);
  endtask

  task automatic send_data(logic [7:0] b);
    send_item(OP_DATA, {b, 24'($urandom)});
  endtask

  task automatic send_start(logic [7:0] ty, logic [7:0] len, logic [7:0] lead);
    send_item(OP_START, {8'($urandom), lead, len, ty});
  endtask

  // a stray start while idle opens a short block
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_start(pick_byte(), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)));
      1:       send_item(OP_RESERVED, $urandom);
      default: send_data(pick_byte());
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYNC) mdl_sync = value;
    else mdl_begin = value;
  endtask

  // ticks until the block is out, handing in bytes as they are wanted
  task automatic finish_block(int feed_pct, bit noisy);
    int r;
    while (mdl_phase != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (noisy && r >= 96) send_noise();
      else if (mdl_need() && r < feed_pct) send_data(pick_byte());
      else send_tick();
    end
  endtask

  task automatic run_block(logic [7:0] ty, logic [7:0] len, logic [7:0] lead,
                           int feed_pct, bit noisy);
    send_start(ty, len, lead);
    finish_block(feed_pct, noisy);
  endtask

  task automatic test_idle_commands();
    send_tick();
    send_data(8'hFF);
    send_data(8'h00);
    send_item(OP_RESERVED, 32'hFFFF_FFFF);
    send_item(OP_RESERVED, 32'h0000_0000);
    send_tick();
  endtask

  task automatic test_register_extremes();
    set_reg(REG_SYNC, 8'h00);
    set_reg(REG_BEGIN, 8'hFF);
    run_block(8'hFF, 8'd0, 8'd0, 50, 1'b0);
    set_reg(REG_SYNC, 8'hFF);
    set_reg(REG_BEGIN, 8'h00);
    run_block(8'h00, 8'd1, 8'd1, 50, 1'b0);
  endtask

  task automatic test_busy_errors();
    send_start(8'h5A, 8'd2, 8'd1);
    send_item(OP_START, 32'hFFFF_FFFF);
    send_item(OP_RESERVED, 32'hFFFF_FFFF);
    send_data(8'hA5);
    send_data(8'h3C);
    while (mdl_data_left != 8'd0) begin
      if (mdl_need()) send_data(pick_byte());
      else send_tick();
    end
    // every data byte taken, block still going
    send_data(8'h77);
    finish_block(0, 1'b0);
  endtask

  task automatic test_output_stall();
    send_start(8'h11, 8'd3, 8'd2);
    hold_output = 1'b1;
    repeat (40) send_tick();
    finish_block(40, 1'b0);
  endtask

  // type plus length wraps the checksum
  task automatic test_longest_block();
    set_reg(REG_SYNC, SYNC_RESET);
    set_reg(REG_BEGIN, BEGIN_RESET);
    run_block(8'hFF, 8'd2, 8'd1, 50, 1'b0);
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct, int unsigned count);
    int unsigned stop_at;
    logic [7:0]  len;
    stop_at = items_sent + count;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) set_reg(reg_idx_t'($urandom_range(0, 1)), pick_byte());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 8)) : 8'($urandom_range(0, 2));
      run_block(pick_byte(), len, 8'($urandom_range(0, 1)), $urandom_range(10, 60), 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    cfg_we = 1'b0;
    cfg_index = REG_SYNC;
    cfg_data = '0;
    fail_count = 0;
    items_sent = 0;
    hold_output = 1'b0;
    src_idle_pct = 18;
    snk_idle_pct = 49;

    mdl_level = 1'b1;
    mdl_phase = PH_IDLE;
    mdl_tick = '0;
    mdl_bit = '0;
    mdl_shift = '0;
    mdl_leader = '0;
    mdl_data_left = '0;
    mdl_len = '0;
    mdl_sum = '0;
    mdl_held = '0;
    mdl_held_full = 1'b0;
    mdl_sync = SYNC_RESET;
    mdl_begin = BEGIN_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_register_extremes();
    test_busy_errors();
    test_output_stall();
    test_longest_block();
    test_random(18, 49, 100);
    test_random(49, 18, 100);
    test_random(0, 0, 100);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
